// ----- rtl/generational_handle_pool_macros.svh -----
// Assertion macros shared by the handle pool RTL.
`ifndef GENERATIONAL_HANDLE_POOL_MACROS_SVH
`define GENERATIONAL_HANDLE_POOL_MACROS_SVH

// Same-cycle implication.
`define HPOOL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define HPOOL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/hpool_pkg.sv -----
// Types and constants of the generational handle pool.
`default_nettype none

package hpool_pkg;

   typedef enum logic [1:0] {
      ACT_ALLOCATE = 2'd0,
      ACT_RELEASE  = 2'd1,
      ACT_SET      = 2'd2,
      ACT_GET      = 2'd3
   } action_type;

   localparam logic [31:0] GEN_RESET = 32'd1;
   localparam logic [31:0] GEN_MAX   = 32'hFFFF_FFFF;
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      action_type  action;
      logic [7:0]  slot_index;
      logic [31:0] handle_generation;
      logic [31:0] write_value;
   } req_beat_type;

   typedef struct packed {
      logic        ok;
      logic [2:0]  granted_index;
      logic [31:0] granted_generation;
      logic [31:0] read_value;
      logic [31:0] rejected_count;
   } rsp_beat_type;

endpackage

`default_nettype wire

// ----- rtl/hpool_req_if.sv -----
// Request channel of the handle pool.
`default_nettype none

interface hpool_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [7:0]  slot_index;
   logic [31:0] handle_generation;
   logic [31:0] write_value;

   modport source (output valid, action, slot_index, handle_generation, write_value,
                   input ready);
   modport sink   (input valid, action, slot_index, handle_generation, write_value,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/hpool_rsp_if.sv -----
// Response channel of the handle pool.
`default_nettype none

interface hpool_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [2:0]  granted_index;
   logic [31:0] granted_generation;
   logic [31:0] read_value;
   logic [31:0] rejected_count;

   modport source (output valid, ok, granted_index, granted_generation, read_value,
                   rejected_count, input ready);
   modport sink   (input valid, ok, granted_index, granted_generation, read_value,
                   rejected_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/hpool_find_free.sv -----
// Lowest-set-bit encoder over the free-slot mask.
`default_nettype none

module hpool_find_free #(
   parameter int SLOT_COUNT = 8,
   parameter int IDX_W      = 3
) (
   input  wire logic [SLOT_COUNT-1:0] free_mask,
   output logic                       any_free,
   output logic [IDX_W-1:0]           free_idx
);

   logic [SLOT_COUNT-1:0] lowest;

   // isolate lowest set bit, then OR the one-hot position into an index
   assign lowest   = free_mask & (~free_mask + SLOT_COUNT'(1));
   assign any_free = |free_mask;

   always_comb begin
      free_idx = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (lowest[i]) begin
            free_idx = free_idx | IDX_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/generational_handle_pool.sv -----
// Top level of the generational handle pool.
// Usage:
//  - req: one beat per request (allocate, release, set, get) with a handle
//    (slot_index, handle_generation) and a value for set.
//  - rsp: exactly one beat per request, in order: ok, granted index and
//    generation for allocate, read value for get, and the saturating count of
//    refused releases.
//  - Pipeline: a taken request is held in the input register, then the slot
//    table is read and updated and the result registered in the response
//    register. Throughput: one request per cycle unless the response stalls,
//    set by the read-modify-write of the register-held slot table.
//  - Reset (synchronous): all slots free, not retired, generation 1, value 0,
//    refused count 0; both pipeline registers empty.
//  - Stall: while rsp.ready is low a pending response holds, the input
//    register holds its request and req.ready drops once both are full.
`default_nettype none
`include "generational_handle_pool_macros.svh"

module generational_handle_pool #(
   parameter int SLOT_COUNT = 8
) (
   input wire logic   clock,
   input wire logic   reset,
   hpool_req_if.sink  req,
   hpool_rsp_if.source rsp
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // pipeline registers
   logic                    in_valid_ff, in_valid_in;
   hpool_pkg::req_beat_type in_beat_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   hpool_pkg::rsp_beat_type rsp_beat_ff, rsp_beat_in;

   // slot table
   logic [SLOT_COUNT-1:0]   in_use_ff, in_use_in;
   logic [SLOT_COUNT-1:0]   retired_ff, retired_in;
   logic [31:0]             gen_ff   [SLOT_COUNT];
   logic [31:0]             value_ff [SLOT_COUNT];
   logic [31:0]             rej_ff, rej_in;

   logic                    req_fire;
   logic                    advance;
   hpool_pkg::action_type   act;
   logic [IDX_W-1:0]        idx_sel;
   logic                    in_range;
   logic                    any_free;
   logic [IDX_W-1:0]        free_idx;
   logic [IDX_W-1:0]        gen_raddr;
   logic [31:0]             gen_rd;
   logic                    live;
   logic                    alloc_grant;
   logic                    gen_we;
   logic [31:0]             gen_wdata;
   logic                    value_we;
   logic [IDX_W-1:0]        value_waddr;
   logic [31:0]             value_wdata;

   // handshake
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign req_fire  = req.valid && req.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_beat_ff.action            <= hpool_pkg::action_type'(req.action);
         in_beat_ff.slot_index        <= req.slot_index;
         in_beat_ff.handle_generation <= req.handle_generation;
         in_beat_ff.write_value       <= req.write_value;
      end
      if (advance) begin
         rsp_beat_ff <= rsp_beat_in;
      end
   end

   // lowest free, unretired slot
   hpool_find_free #(
      .SLOT_COUNT (SLOT_COUNT),
      .IDX_W      (IDX_W)
   ) u_find_free (
      .free_mask (~in_use_ff & ~retired_ff),
      .any_free  (any_free),
      .free_idx  (free_idx)
   );

   assign act      = in_beat_ff.action;
   assign idx_sel  = in_beat_ff.slot_index[IDX_W-1:0];
   assign in_range = {1'b0, in_beat_ff.slot_index} < 9'(SLOT_COUNT);

   // one generation read port, shared by allocate and the handle check
   assign gen_raddr = (act == hpool_pkg::ACT_ALLOCATE) ? free_idx : idx_sel;
   assign gen_rd    = gen_ff[gen_raddr];
   assign live      = in_range && in_use_ff[idx_sel]
                      && (gen_rd == in_beat_ff.handle_generation);
   assign alloc_grant = advance && (act == hpool_pkg::ACT_ALLOCATE) && any_free;

   always_comb begin
      in_use_in   = in_use_ff;
      retired_in  = retired_ff;
      rej_in      = rej_ff;
      gen_we      = 1'b0;
      gen_wdata   = in_beat_ff.handle_generation + 32'd1;
      value_we    = 1'b0;
      value_waddr = idx_sel;
      value_wdata = in_beat_ff.write_value;

      rsp_beat_in                    = '0;

      unique case (act)
         hpool_pkg::ACT_ALLOCATE: begin
            if (any_free) begin
               in_use_in[free_idx]            = 1'b1;
               value_we                       = advance;
               value_waddr                    = free_idx;
               value_wdata                    = '0;
               rsp_beat_in.ok                 = 1'b1;
               rsp_beat_in.granted_index      = 3'(free_idx);
               rsp_beat_in.granted_generation = gen_rd;
            end
         end
         hpool_pkg::ACT_RELEASE: begin
            if (live) begin
               in_use_in[idx_sel] = 1'b0;
               // a slot at the last generation is retired instead of wrapping
               if (in_beat_ff.handle_generation == hpool_pkg::GEN_MAX) begin
                  retired_in[idx_sel] = 1'b1;
               end else begin
                  gen_we = advance;
               end
               rsp_beat_in.ok = 1'b1;
            end else if (rej_ff != hpool_pkg::COUNT_MAX) begin
               rej_in = rej_ff + 32'd1;
            end
         end
         hpool_pkg::ACT_SET: begin
            if (live) begin
               value_we       = advance;
               rsp_beat_in.ok = 1'b1;
            end
         end
         hpool_pkg::ACT_GET: begin
            if (live) begin
               rsp_beat_in.read_value = value_ff[idx_sel];
               rsp_beat_in.ok         = 1'b1;
            end
         end
         default: begin
         end
      endcase

      rsp_beat_in.rejected_count = rej_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff  <= '0;
         retired_ff <= '0;
         rej_ff     <= '0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            gen_ff[i]   <= hpool_pkg::GEN_RESET;
            value_ff[i] <= '0;
         end
      end else begin
         if (advance) begin
            in_use_ff  <= in_use_in;
            retired_ff <= retired_in;
            rej_ff     <= rej_in;
         end
         if (gen_we) begin
            gen_ff[idx_sel] <= gen_wdata;
         end
         if (value_we) begin
            value_ff[value_waddr] <= value_wdata;
         end
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.ok                 = rsp_beat_ff.ok;
   assign rsp.granted_index      = rsp_beat_ff.granted_index;
   assign rsp.granted_generation = rsp_beat_ff.granted_generation;
   assign rsp.read_value         = rsp_beat_ff.read_value;
   assign rsp.rejected_count     = rsp_beat_ff.rejected_count;

   `HPOOL_ASSERT_NOW(a_retired_not_in_use, clock, reset, 1'b1, (retired_ff & in_use_ff) == '0, "retired slot is in use")
   `HPOOL_ASSERT_NEXT(a_rej_monotonic, clock, reset, 1'b1, rej_ff >= $past(rej_ff), "refused count went down")
   `HPOOL_ASSERT_NEXT(a_grant_marks_used, clock, reset, alloc_grant, in_use_ff[$past(free_idx)], "granted slot not marked in use")
   `HPOOL_ASSERT_NOW(a_out_of_range_refused, clock, reset, advance && (act != hpool_pkg::ACT_ALLOCATE) && !in_range, !rsp_beat_in.ok, "out-of-range handle accepted")

endmodule

`default_nettype wire

// ----- bench/pool_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the handle pool: predicts every response beat and compares it.
module pool_checker
   import hpool_pkg::*;
#(
   parameter int SLOT_COUNT = 8
) (
   input wire logic clock,
   input wire logic reset,
   hpool_req_if     req_mon,
   hpool_rsp_if     rsp_mon,
   output int       fail_count
);

   logic         slot_busy    [SLOT_COUNT];
   logic         slot_retired [SLOT_COUNT];
   logic [31:0]  slot_gen     [SLOT_COUNT];
   logic [31:0]  slot_data    [SLOT_COUNT];
   logic [31:0]  refused_releases;
   rsp_beat_type expected_rsps[$];

   initial fail_count = 0;

   function automatic logic handle_is_live(logic [7:0] idx, logic [31:0] gen);
      if (idx >= SLOT_COUNT) return 1'b0;
      return slot_busy[idx] && (slot_gen[idx] == gen);
   endfunction

   // Updates the pool state for one request and returns the response it causes.
   function automatic rsp_beat_type apply_request(req_beat_type beat);
      rsp_beat_type res;
      bit           found;
      res   = '0;
      found = 1'b0;
      case (beat.action)
         ACT_ALLOCATE: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (!found && !slot_busy[i] && !slot_retired[i]) begin
                  found                  = 1'b1;
                  slot_busy[i]           = 1'b1;
                  slot_data[i]           = '0;
                  res.ok                 = 1'b1;
                  res.granted_index      = 3'(i);
                  res.granted_generation = slot_gen[i];
               end
            end
         end
         ACT_RELEASE: begin
            if (handle_is_live(beat.slot_index, beat.handle_generation)) begin
               slot_busy[beat.slot_index] = 1'b0;
               // top generation retires the slot, its generation stays put
               if (beat.handle_generation == GEN_MAX)
                  slot_retired[beat.slot_index] = 1'b1;
               else
                  slot_gen[beat.slot_index] = beat.handle_generation + 32'd1;
               res.ok = 1'b1;
            end else if (refused_releases != COUNT_MAX) begin
               refused_releases = refused_releases + 32'd1;
            end
         end
         ACT_SET: begin
            if (handle_is_live(beat.slot_index, beat.handle_generation)) begin
               slot_data[beat.slot_index] = beat.write_value;
               res.ok = 1'b1;
            end
         end
         default: begin
            if (handle_is_live(beat.slot_index, beat.handle_generation)) begin
               res.read_value = slot_data[beat.slot_index];
               res.ok         = 1'b1;
            end
         end
      endcase
      res.rejected_count = refused_releases;
      return res;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_beat_type want;
      req_beat_type beat;
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_busy[i]    = 1'b0;
            slot_retired[i] = 1'b0;
            slot_gen[i]     = GEN_RESET;
            slot_data[i]    = '0;
         end
         refused_releases = '0;
         expected_rsps.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: response beat with nothing expected, expected none, actual %h",
                        $time, {rsp_mon.ok, rsp_mon.granted_index,
                                rsp_mon.granted_generation, rsp_mon.read_value,
                                rsp_mon.rejected_count});
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("ok", 32'(want.ok), 32'(rsp_mon.ok));
               check_field("granted_index", 32'(want.granted_index),
                           32'(rsp_mon.granted_index));
               check_field("granted_generation", want.granted_generation,
                           rsp_mon.granted_generation);
               check_field("read_value", want.read_value, rsp_mon.read_value);
               check_field("rejected_count", want.rejected_count, rsp_mon.rejected_count);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            beat.action            = action_type'(req_mon.action);
            beat.slot_index        = req_mon.slot_index;
            beat.handle_generation = req_mon.handle_generation;
            beat.write_value       = req_mon.write_value;
            expected_rsps.push_back(apply_request(beat));
         end
      end
   end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the handle pool: clock, reset, request traffic and verdict.
module tb_top;
   import hpool_pkg::*;

   localparam int SLOT_COUNT = 8;
   localparam int IDLE_LIMIT = 5000;

   typedef struct packed {
      logic [7:0]  idx;
      logic [31:0] gen;
   } handle_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   int         fail_count;
   int         idle_pct  = 0;
   int         stall_pct = 0;
   int         quiet_cycles = 0;
   action_type sent_actions[$];
   handle_type granted_handles[$];

   hpool_req_if req_ch();
   hpool_rsp_if rsp_ch();

   generational_handle_pool #(.SLOT_COUNT(SLOT_COUNT)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   pool_checker #(.SLOT_COUNT(SLOT_COUNT)) checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_ch.valid             = 1'b0;
      req_ch.action            = ACT_ALLOCATE;
      req_ch.slot_index        = '0;
      req_ch.handle_generation = '0;
      req_ch.write_value       = '0;
      rsp_ch.ready             = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Learn granted handles so that most traffic targets live slots.
   always @(posedge clock) begin
      action_type act;
      if (!reset && rsp_ch.valid && rsp_ch.ready && sent_actions.size() != 0) begin
         act = sent_actions.pop_front();
         if (act == ACT_ALLOCATE && rsp_ch.ok)
            granted_handles.push_back({5'd0, rsp_ch.granted_index, rsp_ch.granted_generation});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic send_request(action_type act, logic [7:0] idx, logic [31:0] gen,
                               logic [31:0] wval);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid             <= 1'b1;
      req_ch.action            <= act;
      req_ch.slot_index        <= idx;
      req_ch.handle_generation <= gen;
      req_ch.write_value       <= wval;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_actions.push_back(act);
   endtask

   task automatic drain_pool_traffic();
      req_ch.valid <= 1'b0;
      while (sent_actions.size() != 0) @(posedge clock);
   endtask

   task automatic random_requests(int n);
      int         pick;
      int         pos;
      handle_type h;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(99);
         if (granted_handles.size() == 0 || pick < 20) begin
            send_request(ACT_ALLOCATE, 8'($urandom), $urandom, $urandom);
         end else if (pick < 85) begin
            pos = $urandom_range(granted_handles.size() - 1);
            h   = granted_handles[pos];
            if (pick < 40) begin
               send_request(ACT_SET, h.idx, h.gen, $urandom);
            end else if (pick < 60) begin
               send_request(ACT_GET, h.idx, h.gen, $urandom);
            end else if (pick < 75) begin
               granted_handles.delete(pos);
               send_request(ACT_RELEASE, h.idx, h.gen, $urandom);
            end else begin
               // near miss: neighbor generation or neighbor slot
               if ($urandom_range(1))
                  h.gen = $urandom_range(1) ? h.gen + 32'd1 : h.gen - 32'd1;
               else
                  h.idx = h.idx ^ 8'($urandom_range(1, 8));
               send_request(action_type'($urandom_range(1, 3)), h.idx, h.gen, $urandom);
            end
         end else begin
            send_request(action_type'($urandom_range(3)), 8'($urandom), $urandom, $urandom);
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // unused handles right after reset
      send_request(ACT_GET, 8'd0, GEN_RESET, 32'd0);
      send_request(ACT_RELEASE, 8'd0, GEN_RESET, 32'd0);
      // fill the pool, operands of allocate are don't-care
      send_request(ACT_ALLOCATE, 8'hFF, GEN_MAX, 32'hFFFF_FFFF);
      for (int i = 0; i < SLOT_COUNT - 1; i++)
         send_request(ACT_ALLOCATE, 8'($urandom), $urandom, $urandom);
      send_request(ACT_ALLOCATE, 8'd0, 32'd0, 32'd0);
      send_request(ACT_SET, 8'd0, GEN_RESET, 32'hFFFF_FFFF);
      send_request(ACT_GET, 8'd0, GEN_RESET, 32'd0);
      send_request(ACT_SET, 8'd7, GEN_RESET, 32'd0);
      send_request(ACT_GET, 8'd7, GEN_RESET, 32'hFFFF_FFFF);
      // index out of range and stale generations
      send_request(ACT_SET, 8'd8, GEN_RESET, 32'h1234_5678);
      send_request(ACT_GET, 8'hFF, GEN_RESET, 32'd0);
      send_request(ACT_GET, 8'd0, GEN_MAX, 32'd0);
      send_request(ACT_SET, 8'd0, 32'd0, 32'hA5A5_A5A5);
      send_request(ACT_RELEASE, 8'd3, GEN_RESET, 32'd0);
      send_request(ACT_RELEASE, 8'd3, GEN_RESET, 32'd0);
      send_request(ACT_RELEASE, 8'hFF, 32'd0, 32'd0);
      send_request(ACT_ALLOCATE, 8'd0, 32'd0, 32'd0);
      send_request(ACT_GET, 8'd3, GEN_RESET + 32'd1, 32'd0);
      send_request(ACT_GET, 8'd0, GEN_RESET, 32'd0);
      drain_pool_traffic();

      idle_pct = 0;  stall_pct = 0;  random_requests(125);
      drain_pool_traffic();
      idle_pct = 51; stall_pct = 0;  random_requests(125);
      drain_pool_traffic();
      idle_pct = 0;  stall_pct = 51; random_requests(125);
      drain_pool_traffic();
      idle_pct = 11; stall_pct = 11; random_requests(125);

      drain_pool_traffic();
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
